@@ hw/rtl/owbm_pkg.sv @@
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the 1-Wire bus master: phase and command
// codes, register indexes, fixed gap lengths and the queued transaction.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int CNT_W      = 10;
    localparam int BYTE_W     = 8;
    localparam int ACTION_W   = 3;
    localparam int BIT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CNT_W-1:0]     CNT_MAX            = 10'd1023;
    localparam logic [CNT_W-1:0]     RESET_SETTLE_TICKS = 10'd410;
    localparam logic [CNT_W-1:0]     READ_GAP_TICKS     = 10'd6;
    localparam logic [CNT_W-1:0]     WRITE_GAP_TICKS    = 10'd5;
    localparam logic [BIT_IDX_W-1:0] BITS_PER_BYTE      = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_RST_LOW    = 4'd1,
        PH_RST_WAIT   = 4'd2,
        PH_RST_SETTLE = 4'd3,
        PH_WR_LOW     = 4'd4,
        PH_WR_REC     = 4'd5,
        PH_RD_LOW     = 4'd6,
        PH_RD_WAIT    = 4'd7,
        PH_RD_TAIL    = 4'd8,
        PH_RD_GAP     = 4'd9,
        PH_WR_GAP     = 4'd10
    } phase_t;

    typedef enum logic [ACTION_W-1:0] {
        OP_NONE  = 3'd0,
        OP_RESET = 3'd1,
        OP_WBIT  = 3'd2,
        OP_RBIT  = 3'd3,
        OP_WBYTE = 3'd4,
        OP_RBYTE = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_LOW_SHORT        = 3'd0,
        CFG_WRITE_ONE_RECOVERY    = 3'd1,
        CFG_SLOT_LOW_LONG         = 3'd2,
        CFG_WRITE_ZERO_RECOVERY   = 3'd3,
        CFG_READ_SAMPLE_DELAY     = 3'd4,
        CFG_READ_TAIL             = 3'd5,
        CFG_RESET_LOW_TIME        = 3'd6,
        CFG_PRESENCE_SAMPLE_DELAY = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic              is_cmd;
        logic              nonzero;
        op_t               op;
        logic [BYTE_W-1:0] data;
        logic              dq;
        logic              tick;
    } owbm_item_t;

endpackage

@@ hw/rtl/owbm_front.sv @@
// ----------------------------------------------------------------------------
// owbm_front
// Accepts input transactions, decodes the action into a command class and
// holds the decoded transactions in a short queue for the sequencer.
// ----------------------------------------------------------------------------
module owbm_front import owbm_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [BYTE_W-1:0]   data_in,
    input  logic                dq_level,
    input  logic                tick,
    output logic                q_valid,
    output owbm_item_t          q_item,
    input  logic                q_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_Q_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_Q_W-1:0] CNT_FULL = CNT_Q_W'(DEPTH);

    owbm_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q_W-1:0]  count_reg, count_next;
    owbm_item_t          item;
    logic                push;

    always_comb
    begin
        item.is_cmd  = (action >= OP_RESET) && (action <= OP_RBYTE);
        item.nonzero = (action != OP_NONE);
        item.op      = item.is_cmd ? op_t'(action) : OP_NONE;
        item.data    = data_in;
        item.dq      = dq_level;
        item.tick    = tick;
    end

    assign in_ready = (count_reg != CNT_FULL);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_Q_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CNT_Q_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    ap_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (count_reg != '0))
        else $error("Queue popped while empty.");

    ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("Queue count exceeds its depth.");

endmodule

@@ hw/rtl/owbm_back.sv @@
// ----------------------------------------------------------------------------
// owbm_back
// Bus sequencer: carries out one queued transaction per cycle against the
// timing registers while no result waits unread; results sit in a register.
// ----------------------------------------------------------------------------
module owbm_back import owbm_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 q_valid,
    input  owbm_item_t           q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 dq_drive_low,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [BYTE_W-1:0]    read_data,
    output logic                 presence,
    output logic                 rejected
);

    logic [CNT_W-1:0] slot_low_short_reg;
    logic [CNT_W-1:0] write_one_recovery_reg;
    logic [CNT_W-1:0] slot_low_long_reg;
    logic [CNT_W-1:0] write_zero_recovery_reg;
    logic [CNT_W-1:0] read_sample_delay_reg;
    logic [CNT_W-1:0] read_tail_reg;
    logic [CNT_W-1:0] reset_low_time_reg;
    logic [CNT_W-1:0] presence_sample_delay_reg;

    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [BYTE_W-1:0]    shift_reg, shift_next;
    logic                 pres_reg, pres_next;
    op_t                  op_reg, op_next;

    logic                 out_valid_reg;
    logic                 drive_reg, busy_reg, done_reg, pres_out_reg, rej_reg;
    logic [BYTE_W-1:0]    rdata_reg;

    logic                 done_c, rej_c;
    logic [CNT_W-1:0]     cnt_inc, phase_len;

    assign q_pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:    phase_len = reset_low_time_reg;
            PH_RST_WAIT:   phase_len = presence_sample_delay_reg;
            PH_RST_SETTLE: phase_len = RESET_SETTLE_TICKS;
            PH_WR_LOW:     phase_len = shift_reg[0] ? slot_low_short_reg : slot_low_long_reg;
            PH_WR_REC:     phase_len = shift_reg[0] ? write_one_recovery_reg
                                                    : write_zero_recovery_reg;
            PH_RD_LOW:     phase_len = slot_low_short_reg;
            PH_RD_WAIT:    phase_len = read_sample_delay_reg;
            PH_RD_TAIL:    phase_len = read_tail_reg;
            PH_RD_GAP:     phase_len = READ_GAP_TICKS;
            PH_WR_GAP:     phase_len = WRITE_GAP_TICKS;
            default:       phase_len = '0;
        endcase
    end

    assign cnt_inc = (q_item.tick && (cnt_reg != CNT_MAX)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        op_next    = op_reg;
        done_c     = 1'b0;
        rej_c      = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (q_item.is_cmd)
            begin
                op_next  = q_item.op;
                cnt_next = '0;
                bit_next = '0;
                case (q_item.op)
                    OP_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    OP_WBIT:
                    begin
                        shift_next = {{(BYTE_W-1){1'b0}}, q_item.data[0]};
                        phase_next = PH_WR_LOW;
                    end
                    OP_WBYTE:
                    begin
                        shift_next = q_item.data;
                        phase_next = PH_WR_LOW;
                    end
                    OP_RBIT, OP_RBYTE:
                    begin
                        shift_next = '0;
                        phase_next = PH_RD_LOW;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
        else if (phase_reg > PH_WR_GAP)
        begin
            rej_c      = q_item.nonzero;
            phase_next = PH_IDLE;
            cnt_next   = '0;
        end
        else
        begin
            rej_c    = q_item.nonzero;
            cnt_next = cnt_inc;
            if (cnt_inc >= phase_len)
            begin
                cnt_next   = '0;
                phase_next = PH_IDLE;
                case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next  = !q_item.dq;
                        phase_next = PH_RST_SETTLE;
                    end
                    PH_RST_SETTLE:
                    begin
                        done_c = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_REC;
                    end
                    PH_WR_REC:
                    begin
                        shift_next = shift_reg >> 1;
                        bit_next   = bit_reg + BIT_IDX_W'(1);
                        if (op_reg != OP_WBYTE)
                        begin
                            done_c = 1'b1;
                        end
                        else
                        begin
                            phase_next = (bit_next >= BITS_PER_BYTE) ? PH_WR_GAP : PH_WR_LOW;
                        end
                    end
                    PH_WR_GAP:
                    begin
                        done_c = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:
                    begin
                        if (q_item.dq)
                        begin
                            shift_next = shift_reg | (BYTE_W'(1) << bit_reg[2:0]);
                        end
                        phase_next = PH_RD_TAIL;
                    end
                    PH_RD_TAIL:
                    begin
                        bit_next = bit_reg + BIT_IDX_W'(1);
                        if (op_reg != OP_RBYTE)
                        begin
                            done_c = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RD_GAP;
                        end
                    end
                    PH_RD_GAP:
                    begin
                        if (bit_reg >= BITS_PER_BYTE)
                        begin
                            done_c = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RD_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_low_short_reg        <= 10'd6;
            write_one_recovery_reg    <= 10'd64;
            slot_low_long_reg         <= 10'd60;
            write_zero_recovery_reg   <= 10'd10;
            read_sample_delay_reg     <= 10'd9;
            read_tail_reg             <= 10'd55;
            reset_low_time_reg        <= 10'd480;
            presence_sample_delay_reg <= 10'd70;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SLOT_LOW_SHORT:        slot_low_short_reg        <= cfg_data;
                CFG_WRITE_ONE_RECOVERY:    write_one_recovery_reg    <= cfg_data;
                CFG_SLOT_LOW_LONG:         slot_low_long_reg         <= cfg_data;
                CFG_WRITE_ZERO_RECOVERY:   write_zero_recovery_reg   <= cfg_data;
                CFG_READ_SAMPLE_DELAY:     read_sample_delay_reg     <= cfg_data;
                CFG_READ_TAIL:             read_tail_reg             <= cfg_data;
                CFG_RESET_LOW_TIME:        reset_low_time_reg        <= cfg_data;
                CFG_PRESENCE_SAMPLE_DELAY: presence_sample_delay_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            pres_reg      <= 1'b0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                pres_reg      <= pres_next;
                op_reg        <= op_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            drive_reg    <= (phase_next == PH_RST_LOW) || (phase_next == PH_WR_LOW)
                            || (phase_next == PH_RD_LOW);
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= done_c;
            rdata_reg    <= ((op_next == OP_RBIT) || (op_next == OP_RBYTE)) ? shift_next : '0;
            pres_out_reg <= pres_next;
            rej_reg      <= rej_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dq_drive_low = drive_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign read_data    = rdata_reg;
    assign presence     = pres_out_reg;
    assign rejected     = rej_reg;

    ap_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> !busy_reg)
        else $error("Completion reported while still busy.");

    ap_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && drive_reg) |-> busy_reg)
        else $error("Line driven low outside an operation.");

    ap_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid_reg)
        else $error("Popped transaction produced no result.");

endmodule

@@ hw/rtl/one_wire_bus_master.sv @@
// Accepted transactions are queued; each result is registered when popped.
// Throughput: one transaction per cycle unless an unread result stalls it.
// The input queue (QUEUE_DEPTH entries) and the output register decouple stalls.
// Reset clears the queue, the sequencer to idle and the timing registers to
// their standard-speed defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Bit-level 1-Wire bus master: a decode front end and queue feed a timed
// bus sequencer that returns one result per input transaction.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owbm_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ACTION_W-1:0]  action,
    input  logic [BYTE_W-1:0]    data_in,
    input  logic                 dq_level,
    input  logic                 tick,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 dq_drive_low,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [BYTE_W-1:0]    read_data,
    output logic                 presence,
    output logic                 rejected
);

    logic       q_valid;
    logic       q_pop;
    owbm_item_t q_item;

    owbm_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .data_in  (data_in),
        .dq_level (dq_level),
        .tick     (tick),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    owbm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dq_drive_low (dq_drive_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .presence     (presence),
        .rejected     (rejected)
    );

endmodule
